FILE: rtl/aging_priority_dispatcher_top_defines.svh
// Assertion macros used by the dispatcher checker
`ifndef AGING_PRIORITY_DISPATCHER_TOP_DEFINES_SVH
`define AGING_PRIORITY_DISPATCHER_TOP_DEFINES_SVH

// Assert that a condition implies a property on the same edge
`define APD_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("lbl failed");

// Assert that a condition implies a property on the next edge
`define APD_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("lbl failed");

`endif

FILE: rtl/apd_pkg.sv
// Package: widths, codes and command/status structures of the dispatcher
package apd_pkg;

  localparam int QueueDepth = 128;
  localparam int MaxUnits   = 32;
  localparam int SlotW      = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int UnitW      = 5;
  localparam int ActW       = 6;
  localparam int PrioW      = 33;
  localparam int EntryW     = 4 + 10 + 8 + 32;

  localparam logic [1:0] CmdReport   = 2'd0;
  localparam logic [1:0] CmdDispatch = 2'd1;
  localparam logic [1:0] CmdRelease  = 2'd2;
  localparam logic [1:0] CmdTick     = 2'd3;

  localparam logic [3:0] OcQueued     = 4'd0;
  localparam logic [3:0] OcFull       = 4'd1;
  localparam logic [3:0] OcDispatched = 4'd2;
  localparam logic [3:0] OcNoUnit     = 4'd3;
  localparam logic [3:0] OcNoRequest  = 4'd4;
  localparam logic [3:0] OcReleased   = 4'd5;
  localparam logic [3:0] OcAlreadyFree = 4'd6;
  localparam logic [3:0] OcNoSuchUnit = 4'd7;
  localparam logic [3:0] OcTick       = 4'd8;

  localparam logic [1:0] RegActive = 2'd0;
  localparam logic [1:0] RegSevW   = 2'd1;
  localparam logic [1:0] RegVicW   = 2'd2;

  typedef struct packed {
    logic       load;      // latch the input item
    logic       report;    // write the new entry, count up
    logic       rd_issue;  // read slot at scan index
    logic       cmp;       // compare the returned entry with the best
    logic       rd_last;   // read the last entry for the move
    logic       commit;    // move last entry, count down, busy the unit
    logic       release_u; // free the latched unit
    logic       tick;      // advance time
    logic       emit;      // load the result register
    logic [3:0] outcome;
  } apd_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       empty;
    logic       free_found;
    logic       unit_bad;
    logic       unit_busy;
    logic       scan_done;
    logic       out_busy;
  } apd_sts_t;

endpackage

FILE: rtl/apd_ram.sv
// Generic single-port RAM with registered read
module apd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/apd_datapath.sv
// Datapath: request table, unit pool, time, priority scan and result register
module apd_datapath import apd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic [31:0] in_data_i,
  input  apd_cmd_t    cmd_i,
  output apd_sts_t    sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] out_data_o
);
  logic [ActW-1:0]   active_q;
  logic [7:0]        sevw_q, vicw_q;
  logic [31:0]       now_q;
  logic [CountW-1:0] count_q;
  logic [MaxUnits-1:0] busy_q;
  logic [7:0]        ureq_q [MaxUnits];
  logic [1:0]        cmd_q;
  logic [3:0]        sev_q;
  logic [9:0]        vic_q;
  logic [UnitW-1:0]  uidx_q, free_q;
  logic [SlotW-1:0]  scan_q, rd_slot_q, best_q;
  logic [CountW-1:0] issued_q;
  logic [PrioW-1:0]  bestp_q;
  logic [7:0]        bestid_q;
  logic              have_q;
  logic              out_valid_q;
  logic [31:0]       out_q;

  // RAM port
  logic              we;
  logic [SlotW-1:0]  addr;
  logic [EntryW-1:0] wdata, rdata;

  apd_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [ActW-1:0] n_units;
  assign n_units = (active_q > ActW'(MaxUnits)) ? ActW'(MaxUnits) : active_q;

  logic             found;
  logic [UnitW-1:0] free_u;
  always_comb begin
    found  = 1'b0;
    free_u = '0;
    for (int u = MaxUnits - 1; u >= 0; u--) begin
      if (ActW'(u) < n_units && !busy_q[u]) begin
        found  = 1'b1;
        free_u = UnitW'(u);
      end
    end
  end

  // priority of returned entry: two products then add
  logic [3:0]  r_sev;
  logic [9:0]  r_vic;
  logic [7:0]  r_id;
  logic [31:0] r_arr;
  assign {r_sev, r_vic, r_id, r_arr} = rdata;
  logic [11:0] sev_term;
  logic [17:0] vic_term;
  logic [31:0] age;
  assign sev_term = r_sev * sevw_q;
  assign vic_term = r_vic * vicw_q;
  // age wraps modulo 2^32 before it is widened
  assign age      = now_q - r_arr;
  logic [PrioW-1:0] prio;
  assign prio = PrioW'(sev_term) + PrioW'(vic_term) + PrioW'(age);

  always_comb begin
    we    = 1'b0;
    addr  = scan_q;
    wdata = {sev_q, vic_q, 8'(count_q + 1'b1), now_q};
    if (cmd_i.report) begin
      we   = 1'b1;
      addr = count_q[SlotW-1:0];
    end else if (cmd_i.rd_last) begin
      addr = SlotW'(count_q - 1'b1);
    end else if (cmd_i.commit) begin
      we    = 1'b1;
      addr  = best_q;
      wdata = rdata;
    end
  end

  assign sts_o.command    = cmd_q;
  assign sts_o.full       = (count_q == CountW'(QueueDepth));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.free_found = found;
  assign sts_o.unit_bad   = ({1'b0, uidx_q} >= n_units);
  assign sts_o.unit_busy  = busy_q[uidx_q];
  assign sts_o.scan_done  = (issued_q == count_q);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= ActW'(1);
      sevw_q      <= 8'd50;
      vicw_q      <= 8'd20;
      now_q       <= '0;
      count_q     <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
      for (int u = 0; u < MaxUnits; u++) ureq_q[u] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegActive: active_q <= cfg_data_i[ActW-1:0];
          RegSevW:   sevw_q   <= cfg_data_i;
          RegVicW:   vicw_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.report) count_q <= count_q + 1'b1;
      if (cmd_i.tick) now_q <= now_q + 1'b1;
      if (cmd_i.commit) begin
        count_q        <= count_q - 1'b1;
        busy_q[free_q] <= 1'b1;
        ureq_q[free_q] <= bestid_q;
      end
      if (cmd_i.release_u) begin
        busy_q[uidx_q] <= 1'b0;
        ureq_q[uidx_q] <= '0;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.emit) out_valid_q <= 1'b1;
    end
  end

  logic [7:0] rid;
  logic [UnitW-1:0] uo;
  logic [CountW-1:0] qc;
  always_comb begin
    rid = '0;
    uo  = '0;
    qc  = count_q;
    unique case (cmd_i.outcome)
      OcQueued:     begin rid = 8'(count_q + 1'b1); qc = count_q + 1'b1; end
      // the count already dropped at commit
      OcDispatched: begin rid = bestid_q; uo = free_q; qc = count_q; end
      OcReleased, OcAlreadyFree, OcNoSuchUnit: uo = uidx_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= in_data_i[1:0];
      sev_q  <= in_data_i[5:2];
      vic_q  <= in_data_i[15:6];
      uidx_q <= in_data_i[20:16];
      scan_q   <= '0;
      issued_q <= '0;
      have_q   <= 1'b0;
    end
    if (cmd_i.rd_issue) begin
      free_q    <= free_u;
      rd_slot_q <= scan_q;
      scan_q    <= scan_q + 1'b1;
      issued_q  <= issued_q + 1'b1;
    end
    if (cmd_i.cmp && (!have_q || prio > bestp_q)) begin
      bestp_q  <= prio;
      best_q   <= rd_slot_q;
      bestid_q <= r_id;
      have_q   <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_q <= {7'd0, 8'(qc), uo, rid, cmd_i.outcome};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

FILE: rtl/apd_ctrl.sv
// Controller: sequences one transaction through the datapath
module apd_ctrl import apd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  apd_sts_t sts_i,
  output apd_cmd_t cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StDecode, StScan, StLast, StCommit, StEmit
  } state_e;

  state_e     state_q;
  logic       cmp_q;
  logic [3:0] oc_q;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o         = '0;
    cmd_o.outcome = oc_q;
    cmd_o.load    = in_ready_o && in_valid_i;
    cmd_o.cmp     = cmp_q;
    unique case (state_q)
      StScan:   cmd_o.rd_issue = !sts_i.scan_done;
      StLast:   cmd_o.rd_last  = 1'b1;
      StCommit: cmd_o.commit   = 1'b1;
      StEmit: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.report    = (oc_q == OcQueued);
          cmd_o.release_u = (oc_q == OcReleased);
          cmd_o.tick      = (oc_q == OcTick);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cmp_q   <= 1'b0;
      oc_q    <= OcTick;
    end else begin
      cmp_q <= cmd_o.rd_issue;
      unique case (state_q)
        StIdle: if (in_valid_i) state_q <= StDecode;
        StDecode: begin
          state_q <= StEmit;
          unique case (sts_i.command)
            CmdReport:  oc_q <= sts_i.full ? OcFull : OcQueued;
            CmdDispatch: begin
              if (!sts_i.free_found)  oc_q <= OcNoUnit;
              else if (sts_i.empty)   oc_q <= OcNoRequest;
              else begin
                oc_q    <= OcDispatched;
                state_q <= StScan;
              end
            end
            CmdRelease: oc_q <= sts_i.unit_bad ? OcNoSuchUnit :
                                (sts_i.unit_busy ? OcReleased : OcAlreadyFree);
            default:    oc_q <= OcTick;
          endcase
        end
        // drain the last compare before reading the tail entry
        StScan:   if (sts_i.scan_done && !cmp_q) state_q <= StLast;
        StLast:   state_q <= StCommit;
        StCommit: state_q <= StEmit;
        StEmit:   if (!sts_i.out_busy) state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: rtl/aging_priority_dispatcher_top.sv
// Top level: aging priority request table with a pool of service units
//  channel | dir | handshake            | payload
//  s_axis  | in  | s_axis_tvalid/tready | tdata: command, severity, victims, unit_index
//  m_axis  | out | m_axis_tvalid/tready | tdata: outcome, request_id, unit_out, queue_count
//  cfg     | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
// Report, release and tick pass idle, decode and emit; dispatch also scans the table,
// reading the table RAM one slot per cycle, then reads the last entry and commits.
// One transaction at a time; a stalled result holds the controller in emit.
// Reset: all units free, table empty, time zero; no clearing pass.
module aging_priority_dispatcher_top import apd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata, // command[1:0] severity[5:2] victims[15:6] unit_index[20:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata, // outcome[3:0] request_id[11:4] unit_out[16:12] queue_count[24:17]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  apd_cmd_t cmd;
  apd_sts_t sts;

  apd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  apd_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_data_i({8'd0, s_axis_tdata}), .cmd_i(cmd), .sts_o(sts),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid), .out_data_o(m_axis_tdata)
  );
endmodule

FILE: rtl/apd_checker.sv
// Port-level checker for the dispatcher, bound to the top level
`include "aging_priority_dispatcher_top_defines.svh"
module apd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  `APD_ASSERT_NXT(a_one_outstanding, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `APD_ASSERT_NXT(a_hold_data, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `APD_ASSERT_IMP(a_outcome_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd8)
  `APD_ASSERT_IMP(a_count_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[24:17] <= 8'd128)
endmodule

bind aging_priority_dispatcher_top apd_checker u_apd_checker (.*);
